>>> design/urbdt_pkg.sv
package urbdt_pkg;

  typedef enum logic [2:0] {
    FN_HOST_WR   = 3'd0,
    FN_HOST_RD   = 3'd1,
    FN_LINE_BYTE = 3'd2,
    FN_TX_READY  = 3'd3,
    FN_DMA_DONE  = 3'd4,
    FN_QUERY     = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    REG_RX_RING_SIZE   = 2'd0,
    REG_TX_RING_SIZE   = 2'd1,
    REG_TX_DMA_MODE    = 2'd2,
    REG_RX_DIRECT_MODE = 2'd3
  } reg_idx_t;

  localparam logic [6:0] RING_SIZE_RST = 7'd64;

  typedef struct packed {
    logic [6:0] rx_ring_size;
    logic [6:0] tx_ring_size;
    logic       tx_dma_mode;
    logic       rx_direct_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       host_byte_valid;
    logic       direct_valid;
    logic       send_valid;
    logic       dma_start;
    logic [5:0] dma_addr;
    logic [6:0] dma_len;
    logic [5:0] rx_waiting;
    logic [5:0] tx_free;
    logic       tx_empty;
    logic       ready_irq_enable;
  } res_t;

endpackage

>>> design/urbdt_in_if.sv
interface urbdt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] data_byte;
  logic [6:0] dma_remaining;

  modport source (output valid, output func, output data_byte, output dma_remaining,
                  input ready);
  modport sink (input valid, input func, input data_byte, input dma_remaining,
                output ready);
endinterface

>>> design/urbdt_out_if.sv
interface urbdt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       host_byte_valid;
  logic       direct_valid;
  logic       send_valid;
  logic       dma_start;
  logic [5:0] dma_addr;
  logic [6:0] dma_len;
  logic [5:0] rx_waiting;
  logic [5:0] tx_free;
  logic       tx_empty;
  logic       ready_irq_enable;

  modport source (output valid, output byte_out, output host_byte_valid,
                  output direct_valid, output send_valid, output dma_start,
                  output dma_addr, output dma_len, output rx_waiting, output tx_free,
                  output tx_empty, output ready_irq_enable, input ready);
  modport sink (input valid, input byte_out, input host_byte_valid,
                input direct_valid, input send_valid, input dma_start,
                input dma_addr, input dma_len, input rx_waiting, input tx_free,
                input tx_empty, input ready_irq_enable, output ready);
endinterface

>>> design/urbdt_ram.sv
module urbdt_ram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/urbdt_ctrl.sv
module urbdt_ctrl #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64,
  localparam int RPW = $clog2(RX_DEPTH),
  localparam int TPW = $clog2(TX_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [2:0]        func,
  input  logic [7:0]        data_byte,
  input  logic [6:0]        dma_remaining,
  input  urbdt_pkg::cfg_t   cfg,
  output urbdt_pkg::res_t   res,
  output logic              rx_we,
  output logic [RPW-1:0]    rx_waddr,
  output logic [RPW-1:0]    rx_raddr,
  output logic              rx_rd_ok,
  output logic              tx_we,
  output logic [TPW-1:0]    tx_waddr,
  output logic [TPW-1:0]    tx_raddr
);
  import urbdt_pkg::*;

  localparam int MPW = (RPW > TPW) ? RPW : TPW;
  localparam int CW  = ((MPW > 7) ? MPW : 7) + 3;

  logic [RPW-1:0] rx_head, rx_tail, rx_head_next, rx_tail_next, rx_head_inc, rx_tail_inc;
  logic [TPW-1:0] tx_head, tx_tail, tx_head_next, tx_tail_next, tx_head_inc, tx_tail_inc;
  logic           dma_idle, dma_busy, ready_irq_on;
  logic           dma_idle_next, dma_busy_next, ready_irq_on_next;
  logic [RPW:0]   rx_fill;

  logic [CW-1:0]  rxs, txs;
  logic [TPW-1:0] chunk_head, chunk_tail;
  logic [CW-1:0]  chunk_len;
  logic signed [CW-1:0] w, used, fr;

  // effective ring sizes, clamped to 2..depth
  always_comb begin
    if (cfg.rx_ring_size < 7'd2) begin
      rxs = CW'(2);
    end else if (CW'(cfg.rx_ring_size) > CW'(RX_DEPTH)) begin
      rxs = CW'(RX_DEPTH);
    end else begin
      rxs = CW'(cfg.rx_ring_size);
    end
    if (cfg.tx_ring_size < 7'd2) begin
      txs = CW'(2);
    end else if (CW'(cfg.tx_ring_size) > CW'(TX_DEPTH)) begin
      txs = CW'(TX_DEPTH);
    end else begin
      txs = CW'(cfg.tx_ring_size);
    end
  end

  assign rx_head_inc = (CW'(rx_head) + CW'(1) >= rxs) ? '0 : RPW'(rx_head + 1'b1);
  assign rx_tail_inc = (CW'(rx_tail) + CW'(1) >= rxs) ? '0 : RPW'(rx_tail + 1'b1);
  assign tx_head_inc = (CW'(tx_head) + CW'(1) >= txs) ? '0 : TPW'(tx_head + 1'b1);
  assign tx_tail_inc = (CW'(tx_tail) + CW'(1) >= txs) ? '0 : TPW'(tx_tail + 1'b1);

  // a host write advances the head before the chunk is cut
  always_comb begin
    chunk_head = (func_t'(func) == FN_HOST_WR) ? tx_head_inc : tx_head;
    if (chunk_head > tx_tail) begin
      chunk_len  = CW'(chunk_head) - CW'(tx_tail);
      chunk_tail = chunk_head;
    end else begin
      chunk_len  = (txs > CW'(tx_tail)) ? txs - CW'(tx_tail) : '0;
      chunk_tail = '0;
    end
  end

  // status counts, saturated to 0..63
  always_comb begin
    w = $signed(CW'(rx_head)) - $signed(CW'(rx_tail));
    if (w < 0) begin
      w = w + $signed(rxs);
    end
    if (w < 0) begin
      w = '0;
    end else if (w > $signed(CW'(63))) begin
      w = $signed(CW'(63));
    end
    if (tx_head >= tx_tail) begin
      used = $signed(CW'(tx_head)) - $signed(CW'(tx_tail));
    end else begin
      used = $signed(txs) + $signed(CW'(tx_head)) - $signed(CW'(tx_tail));
    end
    fr = $signed(txs) - $signed(CW'(1)) - used;
    if (cfg.tx_dma_mode) begin
      fr = fr - $signed(CW'(dma_remaining));
    end
    if (fr < 0) begin
      fr = '0;
    end else if (fr > $signed(CW'(63))) begin
      fr = $signed(CW'(63));
    end
  end

  always_comb begin
    res               = '0;
    rx_head_next      = rx_head;
    rx_tail_next      = rx_tail;
    tx_head_next      = tx_head;
    tx_tail_next      = tx_tail;
    dma_idle_next     = dma_idle;
    dma_busy_next     = dma_busy;
    ready_irq_on_next = ready_irq_on;
    rx_we             = 1'b0;
    tx_we             = 1'b0;
    case (func_t'(func))
      FN_HOST_WR: begin
        tx_we        = 1'b1;
        tx_head_next = tx_head_inc;
        if (cfg.tx_dma_mode) begin
          if (!dma_busy) begin
            res.dma_start = 1'b1;
            res.dma_addr  = 6'(tx_tail);
            res.dma_len   = 7'(chunk_len);
            tx_tail_next  = chunk_tail;
            dma_idle_next = 1'b0;
            dma_busy_next = 1'b1;
          end
        end else begin
          ready_irq_on_next = 1'b1;
        end
      end
      FN_HOST_RD: begin
        res.host_byte_valid = 1'b1;
        rx_tail_next        = rx_tail_inc;
      end
      FN_LINE_BYTE: begin
        if (cfg.rx_direct_mode) begin
          res.byte_out     = data_byte;
          res.direct_valid = 1'b1;
        end else begin
          rx_we        = 1'b1;
          rx_head_next = rx_head_inc;
        end
      end
      FN_TX_READY: begin
        if (!cfg.tx_dma_mode && tx_tail != tx_head) begin
          res.send_valid = 1'b1;
          tx_tail_next   = tx_tail_inc;
        end else begin
          ready_irq_on_next = 1'b0;
        end
      end
      FN_DMA_DONE: begin
        if (cfg.tx_dma_mode) begin
          dma_busy_next = 1'b0;
          if (tx_head != tx_tail) begin
            res.dma_start = 1'b1;
            res.dma_addr  = 6'(tx_tail);
            res.dma_len   = 7'(chunk_len);
            tx_tail_next  = chunk_tail;
            dma_idle_next = 1'b0;
            dma_busy_next = 1'b1;
          end else begin
            dma_idle_next = 1'b1;
          end
        end
      end
      FN_QUERY: begin
        res.rx_waiting = 6'(w);
        res.tx_free    = 6'(fr);
        res.tx_empty   = cfg.tx_dma_mode ? dma_idle : (tx_tail == tx_head);
      end
      default: begin
      end
    endcase
    res.ready_irq_enable = ready_irq_on_next;
  end

  assign rx_waddr = rx_head;
  assign rx_raddr = rx_tail;
  assign tx_waddr = tx_head;
  assign tx_raddr = tx_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head      <= '0;
      rx_tail      <= '0;
      tx_head      <= '0;
      tx_tail      <= '0;
      dma_idle     <= 1'b1;
      dma_busy     <= 1'b0;
      ready_irq_on <= 1'b0;
      rx_fill      <= '0;
      rx_rd_ok     <= 1'b0;
    end else if (adv) begin
      rx_head      <= rx_head_next;
      rx_tail      <= rx_tail_next;
      tx_head      <= tx_head_next;
      tx_tail      <= tx_tail_next;
      dma_idle     <= dma_idle_next;
      dma_busy     <= dma_busy_next;
      ready_irq_on <= ready_irq_on_next;
      // the head only steps by one or wraps to 0, so written entries form a
      // prefix; anything at or past the fill mark reads as zero
      rx_rd_ok     <= ({1'b0, rx_tail} < rx_fill);
      if (rx_we && ({1'b0, rx_head} == rx_fill)) begin
        rx_fill <= rx_fill + 1'b1;
      end
    end
  end

endmodule

>>> design/uart_ring_buffers_dma_tx.sv
// Serial port buffer engine with a transmit ring and a receive ring.
// Items enter on req (valid/ready): func selects host write, host read,
// line byte, transmitter ready, DMA done or status query. Each item gives
// exactly one result on rsp (valid/ready), in order.
// Configuration: cfg_wen writes cfg_wdata into register cfg_idx (ring
// sizes, DMA mode, direct mode); write it only while no item is in flight.
// An accepted item sits in the input register until it advances; as it
// advances its pointers and ring entries are updated and the result register
// and the registered ring read are loaded, and rsp.valid rises from the
// result register, where the result waits until rsp takes it.
// Throughput: one item per cycle while rsp is not stalled; each ring memory
// does at most one write and one read per item.
// Reset (rst, synchronous) empties both rings, clears the pointers, marks
// DMA idle and loads the registers with 64, 64, 0, 0; the receive ring
// reads as zeros until written. Items are accepted once reset is released.
// When rsp is stalled the result holds, the input register fills behind
// it and req.ready drops until the result is taken.
module uart_ring_buffers_dma_tx #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  urbdt_in_if.sink   req,
  urbdt_out_if.source rsp,
  input  logic       cfg_wen,
  input  logic [1:0] cfg_idx,
  input  logic [6:0] cfg_wdata
);
  import urbdt_pkg::*;

  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);

  cfg_t       cfg;
  logic       a_valid;
  logic [2:0] a_func;
  logic [7:0] a_data;
  logic [6:0] a_pend;
  logic       b_valid;
  res_t       b_res;
  res_t       res;
  logic       adv;

  logic           rx_we, tx_we, rx_rd_ok;
  logic [RPW-1:0] rx_waddr, rx_raddr;
  logic [TPW-1:0] tx_waddr, tx_raddr;
  logic [7:0]     rx_rd, tx_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rx_ring_size   <= RING_SIZE_RST;
      cfg.tx_ring_size   <= RING_SIZE_RST;
      cfg.tx_dma_mode    <= 1'b0;
      cfg.rx_direct_mode <= 1'b0;
    end else if (cfg_wen) begin
      case (reg_idx_t'(cfg_idx))
        REG_RX_RING_SIZE:   cfg.rx_ring_size   <= cfg_wdata;
        REG_TX_RING_SIZE:   cfg.tx_ring_size   <= cfg_wdata;
        REG_TX_DMA_MODE:    cfg.tx_dma_mode    <= cfg_wdata[0];
        REG_RX_DIRECT_MODE: cfg.rx_direct_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign adv       = a_valid && (!b_valid || rsp.ready);
  assign req.ready = !a_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      a_valid <= 1'b1;
    end else if (adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      a_func <= req.func;
      a_data <= req.data_byte;
      a_pend <= req.dma_remaining;
    end
  end

  urbdt_ctrl #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .func          (a_func),
    .data_byte     (a_data),
    .dma_remaining (a_pend),
    .cfg           (cfg),
    .res           (res),
    .rx_we         (rx_we),
    .rx_waddr      (rx_waddr),
    .rx_raddr      (rx_raddr),
    .rx_rd_ok      (rx_rd_ok),
    .tx_we         (tx_we),
    .tx_waddr      (tx_waddr),
    .tx_raddr      (tx_raddr)
  );

  urbdt_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (adv && rx_we),
    .waddr (rx_waddr),
    .wdata (a_data),
    .re    (adv),
    .raddr (rx_raddr),
    .rdata (rx_rd)
  );

  urbdt_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (adv && tx_we),
    .waddr (tx_waddr),
    .wdata (a_data),
    .re    (adv),
    .raddr (tx_raddr),
    .rdata (tx_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= 1'b1;
    end else if (rsp.ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_res <= res;
    end
  end

  assign rsp.valid            = b_valid;
  assign rsp.byte_out         = b_res.host_byte_valid ? (rx_rd_ok ? rx_rd : 8'd0) :
                                b_res.send_valid      ? tx_rd : b_res.byte_out;
  assign rsp.host_byte_valid  = b_res.host_byte_valid;
  assign rsp.direct_valid     = b_res.direct_valid;
  assign rsp.send_valid       = b_res.send_valid;
  assign rsp.dma_start        = b_res.dma_start;
  assign rsp.dma_addr         = b_res.dma_addr;
  assign rsp.dma_len          = b_res.dma_len;
  assign rsp.rx_waiting       = b_res.rx_waiting;
  assign rsp.tx_free          = b_res.tx_free;
  assign rsp.tx_empty         = b_res.tx_empty;
  assign rsp.ready_irq_enable = b_res.ready_irq_enable;

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> $onehot0({b_res.host_byte_valid, b_res.direct_valid,
                          b_res.send_valid, b_res.dma_start}))
    else $error("result carries more than one kind of byte or chunk");

  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    a_valid && !adv |=> a_valid)
    else $error("stalled item lost from input register");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    b_valid && !rsp.ready |=> b_valid && $stable(b_res))
    else $error("stalled result dropped or changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !a_valid && !b_valid)
    else $error("pipeline not empty after reset");

endmodule
